// File: rtl/rrti_pkg.sv
// Shared types, constants and helpers for the region range inspection block.
// Used by rrti_scan, rrti_divider and roi_range_threshold_inspect_unit.
package rrti_pkg;

	localparam int PIXEL_BITS = 8;
	localparam int IDX_BITS   = 12;
	localparam int DIM_BITS   = 13;
	localparam int CNT_BITS   = 25;
	localparam int SUM_BITS   = 32;
	localparam int AREA_BITS  = 25;
	localparam int PCT_BITS   = 14;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 14;

	localparam int DIV_BITS     = 40;
	localparam int DIV_REM_BITS = 25;
	localparam int DIV_CNT_BITS = 6;
	localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS = 6'd40;

	localparam logic [DIM_BITS-1:0]   MAX_DIM   = 13'd4096;
	localparam logic [PCT_BITS-1:0]   PCT_SCALE = 14'd10000;
	localparam logic [PCT_BITS-1:0]   PCT_MAX   = 14'd10000;
	localparam logic [PIXEL_BITS-1:0] AVG_MAX   = 8'd255;

	localparam logic [CFG_IDX_BITS-1:0] REG_SKIP      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THR_LOW   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_THR_HIGH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PASS_PCT  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROI_LEFT  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROI_TOP   = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROI_WIDTH = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROI_HEIGHT = 3'd7;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] thr_low;
		logic [PIXEL_BITS-1:0] thr_high;
		logic [IDX_BITS-1:0]   roi_left;
		logic [IDX_BITS-1:0]   roi_top;
		logic [DIM_BITS-1:0]   width;
		logic [DIM_BITS-1:0]   height;
	} scan_cfg_t;

	typedef struct packed {
		logic                  in_range;
		logic                  region_end;
		logic [DIM_BITS-1:0]   fail_x;
		logic [DIM_BITS-1:0]   fail_y;
		logic [CNT_BITS-1:0]   cnt_next;
		logic [SUM_BITS-1:0]   sum_next;
	} scan_stat_t;

	// A size of zero acts as one, and a size above the limit acts as the limit.
	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
		logic [DIM_BITS-1:0] r;
		r = v;
		if (v == '0) begin
			r = {{(DIM_BITS-1){1'b0}}, 1'b1};
		end else if (v > MAX_DIM) begin
			r = MAX_DIM;
		end
		return r;
	endfunction

endpackage

// File: rtl/rrti_scan.sv
// Position tracking, range check, in-range count and pixel sum for one region.
// Depends on rrti_pkg for the configuration and status structs.
module rrti_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [rrti_pkg::PIXEL_BITS-1:0]   pixel,
	input  rrti_pkg::scan_cfg_t               cfg,
	output rrti_pkg::scan_stat_t              stat
);

	logic [rrti_pkg::IDX_BITS-1:0] col_q;
	logic [rrti_pkg::IDX_BITS-1:0] row_q;
	logic [rrti_pkg::CNT_BITS-1:0] cnt_q;
	logic [rrti_pkg::SUM_BITS-1:0] sum_q;
	logic                          col_end;

	always_comb begin
		stat.in_range   = (pixel >= cfg.thr_low) && (pixel <= cfg.thr_high);
		col_end         = ({1'b0, row_q} + 13'd1) >= cfg.height;
		stat.region_end = col_end && (({1'b0, col_q} + 13'd1) >= cfg.width);
		stat.fail_x     = {1'b0, cfg.roi_left} + {1'b0, col_q};
		stat.fail_y     = {1'b0, cfg.roi_top} + {1'b0, row_q};
		stat.cnt_next   = cnt_q + rrti_pkg::CNT_BITS'(stat.in_range);
		stat.sum_next   = sum_q + rrti_pkg::SUM_BITS'(pixel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (advance) begin
			if (stat.region_end) begin
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				cnt_q <= stat.cnt_next;
				sum_q <= stat.sum_next;
				if (col_end) begin
					row_q <= '0;
					col_q <= col_q + 12'd1;
				end else begin
					row_q <= row_q + 12'd1;
				end
			end
		end
	end

endmodule

// File: rtl/rrti_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on rrti_pkg for the operand widths and the step count.
module rrti_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [rrti_pkg::DIV_BITS-1:0]       numer,
	input  logic [rrti_pkg::AREA_BITS-1:0]      denom,
	output logic                                done,
	output logic [rrti_pkg::DIV_BITS-1:0]       quot
);

	logic [rrti_pkg::DIV_BITS-1:0]     nq_q;
	logic [rrti_pkg::DIV_REM_BITS-1:0] rem_q;
	logic [rrti_pkg::AREA_BITS-1:0]    denom_q;
	logic [rrti_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic                              run_q;
	logic                              done_q;
	logic [rrti_pkg::DIV_REM_BITS:0]   trial;
	logic                              fits;
	logic [rrti_pkg::DIV_REM_BITS:0]   diff;

	always_comb begin
		trial = {rem_q, nq_q[rrti_pkg::DIV_BITS-1]};
		fits  = trial >= {1'b0, denom_q};
		diff  = trial - {1'b0, denom_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= rrti_pkg::DIV_STEPS;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q    <= numer;
			rem_q   <= '0;
			denom_q <= denom;
		end else if (run_q) begin
			nq_q <= {nq_q[rrti_pkg::DIV_BITS-2:0], fits};
			if (fits) begin
				rem_q <= diff[rrti_pkg::DIV_REM_BITS-1:0];
			end else begin
				rem_q <= trial[rrti_pkg::DIV_REM_BITS-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = nq_q;

endmodule

// File: rtl/roi_range_threshold_inspect_unit.sv
// Region pixel range inspection: counts, sums and flags pixels, then summarizes.
// A pixel that ends no region leaves the block idle; its fail point is in the output register next cycle.
// At region end with skip clear, the shared 40-step divider runs twice (average, then share);
// the summary reaches the output register after the second run, and no pixel is taken meanwhile.
// Reset loads the register defaults and clears position, count and sum; no clearing pass.
// Depends on rrti_pkg, rrti_scan and rrti_divider.
module roi_range_threshold_inspect_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rrti_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [rrti_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                   pixel_valid,
	output logic                                   pixel_stall,
	input  logic [rrti_pkg::PIXEL_BITS-1:0]        pixel_value,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic                                   kind,
	output logic [rrti_pkg::DIM_BITS-1:0]          x,
	output logic [rrti_pkg::DIM_BITS-1:0]          y,
	output logic [rrti_pkg::CNT_BITS-1:0]          in_range_count,
	output logic [rrti_pkg::PIXEL_BITS-1:0]        average,
	output logic [rrti_pkg::PCT_BITS-1:0]          percent_hundredths,
	output logic                                   pass,
	output logic                                   last
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_AVG_GO   = 3'd1;
	localparam logic [2:0] S_AVG_WAIT = 3'd2;
	localparam logic [2:0] S_PCT_GO   = 3'd3;
	localparam logic [2:0] S_PCT_WAIT = 3'd4;
	localparam logic [2:0] S_EMIT     = 3'd5;

	logic                                skip_q;
	logic [rrti_pkg::PIXEL_BITS-1:0]     thr_low_q;
	logic [rrti_pkg::PIXEL_BITS-1:0]     thr_high_q;
	logic [rrti_pkg::PCT_BITS-1:0]       pass_pct_q;
	logic [rrti_pkg::IDX_BITS-1:0]       roi_left_q;
	logic [rrti_pkg::IDX_BITS-1:0]       roi_top_q;
	logic [rrti_pkg::DIM_BITS-1:0]       width_q;
	logic [rrti_pkg::DIM_BITS-1:0]       height_q;

	logic [2:0]                          state_q;
	logic [rrti_pkg::CNT_BITS-1:0]       cnt_fin_q;
	logic [rrti_pkg::SUM_BITS-1:0]       sum_fin_q;
	logic [rrti_pkg::AREA_BITS-1:0]      area_q;
	logic [rrti_pkg::DIV_BITS-1:0]       prod_q;
	logic [rrti_pkg::PIXEL_BITS-1:0]     avg_q;
	logic [rrti_pkg::PCT_BITS-1:0]       pct_q;

	logic                                out_valid_q;
	logic                                kind_q;
	logic [rrti_pkg::DIM_BITS-1:0]       x_q;
	logic [rrti_pkg::DIM_BITS-1:0]       y_q;
	logic [rrti_pkg::CNT_BITS-1:0]       cnt_out_q;
	logic [rrti_pkg::PIXEL_BITS-1:0]     avg_out_q;
	logic [rrti_pkg::PCT_BITS-1:0]       pct_out_q;
	logic                                pass_q;
	logic                                last_q;

	rrti_pkg::scan_cfg_t                 scan_cfg;
	rrti_pkg::scan_stat_t                scan_stat;
	logic [rrti_pkg::DIM_BITS-1:0]       width_c;
	logic [rrti_pkg::DIM_BITS-1:0]       height_c;
	logic [2*rrti_pkg::DIM_BITS-1:0]     area_full;
	logic                                out_free;
	logic                                accept;
	logic                                fail;
	logic                                div_start;
	logic [rrti_pkg::DIV_BITS-1:0]       div_numer;
	logic                                div_done;
	logic [rrti_pkg::DIV_BITS-1:0]       div_quot;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q     <= 1'b0;
			thr_low_q  <= '0;
			thr_high_q <= 8'd255;
			pass_pct_q <= '0;
			roi_left_q <= '0;
			roi_top_q  <= '0;
			width_q    <= 13'd1;
			height_q   <= 13'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rrti_pkg::REG_SKIP:       skip_q     <= cfg_data[0];
				rrti_pkg::REG_THR_LOW:    thr_low_q  <= cfg_data[7:0];
				rrti_pkg::REG_THR_HIGH:   thr_high_q <= cfg_data[7:0];
				rrti_pkg::REG_PASS_PCT:   pass_pct_q <= cfg_data;
				rrti_pkg::REG_ROI_LEFT:   roi_left_q <= cfg_data[11:0];
				rrti_pkg::REG_ROI_TOP:    roi_top_q  <= cfg_data[11:0];
				rrti_pkg::REG_ROI_WIDTH:  width_q    <= cfg_data[12:0];
				rrti_pkg::REG_ROI_HEIGHT: height_q   <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		width_c            = rrti_pkg::clamp_dim(width_q);
		height_c           = rrti_pkg::clamp_dim(height_q);
		area_full          = {13'd0, width_c} * {13'd0, height_c};
		scan_cfg.thr_low   = thr_low_q;
		scan_cfg.thr_high  = thr_high_q;
		scan_cfg.roi_left  = roi_left_q;
		scan_cfg.roi_top   = roi_top_q;
		scan_cfg.width     = width_c;
		scan_cfg.height    = height_c;
		out_free           = !out_valid_q || !result_stall;
		pixel_stall        = !((state_q == S_IDLE) && out_free);
		accept             = pixel_valid && !pixel_stall;
		fail               = !scan_stat.in_range && !skip_q;
		div_start          = (state_q == S_AVG_GO) || (state_q == S_PCT_GO);
		div_numer          = (state_q == S_AVG_GO) ? rrti_pkg::DIV_BITS'(sum_fin_q) : prod_q;
	end

	rrti_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.pixel  (pixel_value),
		.cfg    (scan_cfg),
		.stat   (scan_stat)
	);

	rrti_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (div_numer),
		.denom (area_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && scan_stat.region_end && !skip_q) begin
						state_q <= S_AVG_GO;
					end
				end
				S_AVG_GO:   state_q <= S_AVG_WAIT;
				S_AVG_WAIT: if (div_done) state_q <= S_PCT_GO;
				S_PCT_GO:   state_q <= S_PCT_WAIT;
				S_PCT_WAIT: if (div_done) state_q <= S_EMIT;
				S_EMIT:     if (out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && scan_stat.region_end) begin
			cnt_fin_q <= scan_stat.cnt_next;
			sum_fin_q <= scan_stat.sum_next;
			area_q    <= area_full[rrti_pkg::AREA_BITS-1:0];
		end
		if (state_q == S_AVG_GO) begin
			prod_q <= {1'b0, 39'(cnt_fin_q) * 39'(rrti_pkg::PCT_SCALE)};
		end
		if ((state_q == S_AVG_WAIT) && div_done) begin
			avg_q <= (div_quot > rrti_pkg::DIV_BITS'(rrti_pkg::AVG_MAX)) ?
				rrti_pkg::AVG_MAX : div_quot[rrti_pkg::PIXEL_BITS-1:0];
		end
		if ((state_q == S_PCT_WAIT) && div_done) begin
			pct_q <= (div_quot > rrti_pkg::DIV_BITS'(rrti_pkg::PCT_MAX)) ?
				rrti_pkg::PCT_MAX : div_quot[rrti_pkg::PCT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && (fail || (scan_stat.region_end && skip_q))) ||
			((state_q == S_EMIT) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fail) begin
			kind_q    <= 1'b0;
			x_q       <= scan_stat.fail_x;
			y_q       <= scan_stat.fail_y;
			cnt_out_q <= '0;
			avg_out_q <= '0;
			pct_out_q <= '0;
			pass_q    <= 1'b0;
			last_q    <= !scan_stat.region_end;
		end else if (accept && scan_stat.region_end && skip_q) begin
			kind_q    <= 1'b1;
			x_q       <= '0;
			y_q       <= '0;
			cnt_out_q <= '0;
			avg_out_q <= '0;
			pct_out_q <= '0;
			pass_q    <= 1'b1;
			last_q    <= 1'b1;
		end else if ((state_q == S_EMIT) && out_free) begin
			kind_q    <= 1'b1;
			x_q       <= '0;
			y_q       <= '0;
			cnt_out_q <= cnt_fin_q;
			avg_out_q <= avg_q;
			pct_out_q <= pct_q;
			pass_q    <= pct_q >= pass_pct_q;
			last_q    <= 1'b1;
		end
	end

	assign result_valid       = out_valid_q;
	assign kind               = kind_q;
	assign x                  = x_q;
	assign y                  = y_q;
	assign in_range_count     = cnt_out_q;
	assign average            = avg_out_q;
	assign percent_hundredths = pct_out_q;
	assign pass               = pass_q;
	assign last               = last_q;

	// The divider finishes only while the sequencer waits for it.
	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_AVG_WAIT) || (state_q == S_PCT_WAIT)))
		else $error("divider finished outside a wait state");

	// A summary beat always closes the results of its pixel.
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind) |-> last)
		else $error("summary beat without last");

	// The reported share never exceeds the full scale.
	a_pct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind) |-> (percent_hundredths <= rrti_pkg::PCT_MAX))
		else $error("percent above full scale");

	// No pixel is taken while a region summary is being computed.
	a_no_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> pixel_stall)
		else $error("pixel taken during summary computation");

endmodule
